[rtl/core/sha256d_nonce_scan_macros.svh]
// Assertion macros for the nonce scanner.
// Used by the top level; no other dependencies.
`ifndef SHA256D_NONCE_SCAN_MACROS_SVH
`define SHA256D_NONCE_SCAN_MACROS_SVH
// implication check under reset
`define SNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check under reset
`define SNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/sns_pkg.sv]
// Shared types, constants and round functions for the nonce scanner.
// No dependencies.
package sns_pkg;
  typedef enum logic [1:0] {OP_HDR = 2'd0, OP_TGT = 2'd1, OP_TEST = 2'd2, OP_NONE = 2'd3} op_t;
  localparam int HDR_WORDS = 19;
  localparam int TGT_WORDS = 8;
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] LEN_HDR = 32'd640;
  localparam logic [31:0] LEN_DIG = 32'd256;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] st_t;     // index 0 = a
  typedef word_t [15:0] win_t;   // index 0 = current w

  function automatic word_t iv_word(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6a09e667; 3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372; 3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f; 3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab; default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t rk(input logic [5:0] i);
    word_t t [64];
    t = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
          32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
          32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
          32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
          32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
          32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
          32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
          32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
          32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
          32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
          32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
          32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
          32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
          32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
          32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return t[i];
  endfunction

  function automatic word_t ror(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t bswap(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // cell-to-cell payload
  typedef struct packed {
    logic  vld;
    logic  [1:0] pass;   // 0 block 1, 1 block 2, 2 digest block
    st_t   st;
    st_t   base;
    win_t  w;
    word_t nonce;
  } link_t;
endpackage

[rtl/core/sns_cell.sv]
// One SHA-256 round cell: round update plus message window shift.
// Depends on sns_pkg.
module sns_cell import sns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [5:0]  rnd,
  input  link_t       din,
  output link_t       dout
);
  link_t dout_r, dout_nxt;
  word_t t1, t2, s0, s1, wn;

  always_comb begin
    t1 = din.st[7] + (ror(din.st[4], 6) ^ ror(din.st[4], 11) ^ ror(din.st[4], 25))
       + ((din.st[4] & din.st[5]) ^ (~din.st[4] & din.st[6])) + rk(rnd) + din.w[0];
    t2 = (ror(din.st[0], 2) ^ ror(din.st[0], 13) ^ ror(din.st[0], 22))
       + ((din.st[0] & din.st[1]) ^ (din.st[0] & din.st[2]) ^ (din.st[1] & din.st[2]));
    s0 = ror(din.w[1], 7) ^ ror(din.w[1], 18) ^ (din.w[1] >> 3);
    s1 = ror(din.w[14], 17) ^ ror(din.w[14], 19) ^ (din.w[14] >> 10);
    wn = s1 + din.w[9] + s0 + din.w[0];
    dout_nxt = din;
    dout_nxt.st[0] = t1 + t2;
    dout_nxt.st[1] = din.st[0];
    dout_nxt.st[2] = din.st[1];
    dout_nxt.st[3] = din.st[2];
    dout_nxt.st[4] = din.st[3] + t1;
    dout_nxt.st[5] = din.st[4];
    dout_nxt.st[6] = din.st[5];
    dout_nxt.st[7] = din.st[6];
    for (int i = 0; i < 15; i++) dout_nxt.w[i] = din.w[i+1];
    dout_nxt.w[15] = wn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.vld <= 1'b0;
    end else if (en) begin
      dout_r <= dout_nxt;
    end
  end
  assign dout = dout_r;
endmodule

[rtl/core/sha256d_nonce_scan.sv]
// Double SHA-256 nonce scanner: a chain of 64 round cells, walked three times
// per nonce (header block 1, header block 2, digest block).
// Each pass runs once through the chain; a result is registered when the digest
// pass leaves it. One nonce at a time: no new test is taken until the result is
// taken or dropped on a miss, set by the single 64-cell chain. Loads wait too.
// Synchronous active-low reset clears both stores to zero.
`include "sha256d_nonce_scan_macros.svh"
module sha256d_nonce_scan import sns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_word_index,
  input  logic [31:0] in_word_value,
  input  logic [31:0] in_nonce,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_found_nonce,
  output logic [63:0] out_hash_top,
  output logic [63:0] out_hash_upper,
  output logic [63:0] out_hash_lower,
  output logic [63:0] out_hash_bottom
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

  state_t state_r;
  word_t  hdr_r [HDR_WORDS];
  word_t  tgt_r [TGT_WORDS];
  link_t  inj;
  link_t  chain [65];
  logic   busy_r;      // an item is inside the chain
  st_t    fin, dig;    // end-of-chain feed-forward sum
  logic   le;
  logic   acc;
  logic [31:0] nonce_r;
  st_t    hash_r;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // feed-forward add at the chain exit
  always_comb begin
    for (int i = 0; i < 8; i++) fin[i] = chain[64].st[i] + chain[64].base[i];
  end

  // inject: either a new nonce or a chain recirculation
  always_comb begin
    inj = '0;
    if (acc && op_t'(in_operation) == OP_TEST) begin
      inj.vld = 1'b1;
      inj.pass = 2'd0;
      inj.nonce = in_nonce;
      for (int i = 0; i < 8; i++) begin
        inj.st[i] = iv_word(3'(i));
        inj.base[i] = iv_word(3'(i));
      end
      for (int i = 0; i < 16; i++) inj.w[i] = hdr_r[i];
    end else if (chain[64].vld && chain[64].pass == 2'd0) begin
      inj.vld = 1'b1;
      inj.pass = 2'd1;
      inj.nonce = chain[64].nonce;
      inj.st = fin;
      inj.base = fin;
      inj.w[0] = hdr_r[16];
      inj.w[1] = hdr_r[17];
      inj.w[2] = hdr_r[18];
      inj.w[3] = bswap(chain[64].nonce);
      inj.w[4] = PAD_WORD;
      inj.w[15] = LEN_HDR;
    end else if (chain[64].vld && chain[64].pass == 2'd1) begin
      inj.vld = 1'b1;
      inj.pass = 2'd2;
      inj.nonce = chain[64].nonce;
      for (int i = 0; i < 8; i++) begin
        inj.st[i] = iv_word(3'(i));
        inj.base[i] = iv_word(3'(i));
        inj.w[i] = fin[i];
      end
      inj.w[8] = PAD_WORD;
      inj.w[15] = LEN_DIG;
    end
  end

  assign chain[0] = inj;
  for (genvar g = 0; g < 64; g++) begin : g_cell
    sns_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(1'b1), .rnd(6'(g)),
      .din(chain[g]), .dout(chain[g+1])
    );
  end

  // 256-bit big-endian compare, fixed 8-word priority
  always_comb begin
    dig = fin;
    le = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (dig[i] != tgt_r[i]) le = (dig[i] < tgt_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r <= 1'b0;
      for (int i = 0; i < HDR_WORDS; i++) hdr_r[i] <= '0;
      for (int i = 0; i < TGT_WORDS; i++) tgt_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            unique case (op_t'(in_operation))
              OP_HDR: if (in_word_index < 5'(HDR_WORDS)) hdr_r[in_word_index] <= in_word_value;
              OP_TGT: if (in_word_index < 5'(TGT_WORDS)) tgt_r[in_word_index[2:0]] <= in_word_value;
              OP_TEST: begin
                state_r <= S_RUN;
                busy_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          if (chain[64].vld && chain[64].pass == 2'd2) begin
            busy_r <= 1'b0;
            nonce_r <= chain[64].nonce;
            hash_r <= fin;
            state_r <= le ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_found_nonce = nonce_r;
  assign out_hash_top    = {hash_r[0], hash_r[1]};
  assign out_hash_upper  = {hash_r[2], hash_r[3]};
  assign out_hash_lower  = {hash_r[4], hash_r[5]};
  assign out_hash_bottom = {hash_r[6], hash_r[7]};

  `SNS_ASSERT_IMP(a_busy_run, busy_r, state_r == S_RUN)
  `SNS_ASSERT_IMP(a_exit_busy, chain[64].vld, busy_r)
  `SNS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_found_nonce))
endmodule

[test/sha256d_nonce_scan_chk.sv]
`timescale 1ns / 100ps
// Checker for the double SHA-256 nonce scanner: watches both channels, keeps
// its own header/target stores, predicts passing nonces and compares results.
// Depends on sns_pkg for the operation codes.
module sha256d_nonce_scan_chk import sns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_word_index,
  input  logic [31:0] in_word_value,
  input  logic [31:0] in_nonce,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_found_nonce,
  input  logic [63:0] out_hash_top,
  input  logic [63:0] out_hash_upper,
  input  logic [63:0] out_hash_lower,
  input  logic [63:0] out_hash_bottom,
  output int          fail_count,
  output int          pending
);
  typedef logic [7:0][31:0]  state8_t;
  typedef logic [15:0][31:0] block16_t;

  typedef struct {
    logic [31:0] nonce;
    logic [63:0] top;
    logic [63:0] upper;
    logic [63:0] lower;
    logic [63:0] bottom;
  } hit_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam state8_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  logic [31:0] hdr_words [19];
  logic [31:0] tgt_words [8];
  hit_t        hit_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic state8_t compress(input state8_t st, input block16_t blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = st[0]; b = st[1]; c = st[2]; d = st[3];
    e = st[4]; f = st[5]; g = st[6]; h = st[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    st[0] += a; st[1] += b; st[2] += c; st[3] += d;
    st[4] += e; st[5] += f; st[6] += g; st[7] += h;
    return st;
  endfunction

  // Double hash of header prefix plus nonce; pushes a hit if digest <= target.
  task automatic predict_nonce(input logic [31:0] nonce);
    block16_t    blk;
    state8_t     s1, s2;
    logic [255:0] dig, tgt;
    hit_t        hit;
    for (int i = 0; i < 16; i++) blk[i] = hdr_words[i];
    s1 = compress(INIT_H, blk);
    blk = '0;
    blk[0] = hdr_words[16];
    blk[1] = hdr_words[17];
    blk[2] = hdr_words[18];
    blk[3] = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
    blk[4] = 32'h8000_0000;
    blk[15] = 32'd640;
    s1 = compress(s1, blk);
    blk = '0;
    for (int i = 0; i < 8; i++) blk[i] = s1[i];
    blk[8] = 32'h8000_0000;
    blk[15] = 32'd256;
    s2 = compress(INIT_H, blk);
    dig = '0;
    tgt = '0;
    for (int i = 0; i < 8; i++) begin
      dig = {dig[223:0], s2[i]};
      tgt = {tgt[223:0], tgt_words[i]};
    end
    if (dig <= tgt) begin
      hit.nonce  = nonce;
      hit.top    = {s2[0], s2[1]};
      hit.upper  = {s2[2], s2[3]};
      hit.lower  = {s2[4], s2[5]};
      hit.bottom = {s2[6], s2[7]};
      hit_q.push_back(hit);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("%0t mismatch %s: got %h exp %h", $time, what, got, exp);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hit_t exp;
    if (!rst_n) begin
      fail_count = 0;
      for (int i = 0; i < 19; i++) hdr_words[i] = '0;
      for (int i = 0; i < 8; i++) tgt_words[i] = '0;
    end else begin
      // result side first
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          report_mismatch("unexpected result nonce", 64'(out_found_nonce), '0);
        end else begin
          exp = hit_q.pop_front();
          if (out_found_nonce !== exp.nonce)
            report_mismatch("found_nonce", 64'(out_found_nonce), 64'(exp.nonce));
          if (out_hash_top !== exp.top) report_mismatch("hash_top", out_hash_top, exp.top);
          if (out_hash_upper !== exp.upper)
            report_mismatch("hash_upper", out_hash_upper, exp.upper);
          if (out_hash_lower !== exp.lower)
            report_mismatch("hash_lower", out_hash_lower, exp.lower);
          if (out_hash_bottom !== exp.bottom)
            report_mismatch("hash_bottom", out_hash_bottom, exp.bottom);
        end
      end
      if (in_valid && !in_stall) begin
        case (op_t'(in_operation))
          OP_HDR: if (in_word_index < 19) hdr_words[in_word_index] = in_word_value;
          OP_TGT: if (in_word_index < 8) tgt_words[in_word_index] = in_word_value;
          OP_TEST: predict_nonce(in_nonce);
          default: ;
        endcase
      end
    end
    pending = hit_q.size();
  end
endmodule

[test/sha256d_nonce_scan_tb.sv]
`timescale 1ns / 100ps
// Top of the nonce scanner testbench: clock, reset, stimulus and verdict.
// Depends on sns_pkg, the scanner RTL and sha256d_nonce_scan_chk.
module sha256d_nonce_scan_tb;
  import sns_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_NONE;
  logic [4:0]  in_word_index = '0;
  logic [31:0] in_word_value = '0;
  logic [31:0] in_nonce = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_found_nonce;
  logic [63:0] out_hash_top, out_hash_upper, out_hash_lower, out_hash_bottom;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          items_sent = 0;

  // Target word 0 thresholds: always pass, roughly half, an eighth, never.
  localparam logic [31:0] TGT_ALL   = 32'hffff_ffff;
  localparam logic [31:0] TGT_HALF  = 32'h7fff_ffff;
  localparam logic [31:0] TGT_EIGHT = 32'h1fff_ffff;
  localparam logic [31:0] TGT_ZERO  = 32'h0000_0000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sha256d_nonce_scan dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_word_index,
    .in_word_value, .in_nonce, .out_valid, .out_stall, .out_found_nonce,
    .out_hash_top, .out_hash_upper, .out_hash_lower, .out_hash_bottom
  );

  sha256d_nonce_scan_chk chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_word_index,
    .in_word_value, .in_nonce, .out_valid, .out_stall, .out_found_nonce,
    .out_hash_top, .out_hash_upper, .out_hash_lower, .out_hash_bottom,
    .fail_count, .pending
  );

  // One transfer on the input channel. Bursts of random length; between
  // bursts valid usually drops for a random gap. Fields hold while stalled.
  task automatic send(input op_t op, input logic [4:0] idx, input logic [31:0] val,
                      input logic [31:0] nonce);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_word_index <= idx;
    in_word_value <= val;
    in_nonce      <= nonce;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load_target(input logic [31:0] w0, input bit rest_ones);
    send(OP_TGT, 5'd0, w0, $urandom);
    for (int i = 1; i < 8; i++)
      send(OP_TGT, 5'(i), rest_ones ? TGT_ALL : $urandom, $urandom);
  endtask

  // Receiver: moves through random stall patterns (none, light,
  // heavy); once, a long hold so the scanner backs up into its input.
  initial begin
    int mode;
    bit held;
    held = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && items_sent > 200) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(100, 600)) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] thr;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of the header, ignored indexes and operation,
    // a target that passes everything, one that passes nothing.
    send(OP_HDR, 5'd0, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_HDR, 5'd18, 32'h0000_0000, 32'h0);
    send(OP_HDR, 5'd19, 32'hffff_ffff, 32'h0);  // header index out of range
    send(OP_HDR, 5'd31, 32'h1234_5678, 32'h0);
    send(OP_TGT, 5'd8, 32'hffff_ffff, 32'h0);   // target index out of range
    send(OP_TGT, 5'd31, 32'hffff_ffff, 32'h0);
    send(OP_NONE, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_TEST, 5'd0, 32'h0, 32'h0);          // target still zero: no hit
    load_target(TGT_ALL, 1'b1);
    send(OP_TEST, 5'd31, 32'hffff_ffff, 32'h0);
    send(OP_TEST, 5'd0, 32'h0, 32'hffff_ffff);
    send(OP_TGT, 5'd0, TGT_ZERO, 32'h0);
    send(OP_TEST, 5'd3, 32'h5555_aaaa, 32'h0001_2345);
    send(OP_TGT, 5'd7, 32'h0, 32'h0);
    send(OP_TGT, 5'd0, TGT_HALF, 32'h0);
    send(OP_TEST, 5'd0, 32'h0, 32'h8000_0001);
    send(OP_TEST, 5'd0, 32'h0, 32'h7fff_fffe);

    // Random: load a target and some header words, then test nonces,
    // with a sprinkle of ignored or malformed items.
    while (items_sent < 850) begin
      case ($urandom_range(0, 4))
        0: thr = TGT_ALL;
        1: thr = TGT_HALF;
        2: thr = TGT_EIGHT;
        3: thr = TGT_ZERO;
        default: thr = $urandom;
      endcase
      load_target(thr, $urandom_range(0, 1));
      repeat ($urandom_range(0, 5))
        send(OP_HDR, 5'($urandom_range(0, 18)), $urandom, $urandom);
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 9) == 0)
          send(op_t'($urandom_range(0, 3)), 5'($urandom), $urandom, $urandom);
        else
          send(OP_TEST, 5'($urandom), $urandom, $urandom);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sns_pkg.sv
rtl/core/sns_cell.sv
rtl/core/sha256d_nonce_scan.sv
test/sha256d_nonce_scan_chk.sv
test/sha256d_nonce_scan_tb.sv
